// File: src/sprs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sprs_pkg;

	// default geometry
	localparam int DEF_PAGE_BYTES       = 4096;
	localparam int DEF_HEADER_BYTES     = 12;
	localparam int DEF_SLOT_ENTRY_BYTES = 4;
	localparam int DEF_MAX_SLOTS        = 1024;

	// command codes carried in s_tuser
	localparam logic [2:0] FN_INIT   = 3'd0;
	localparam logic [2:0] FN_INSERT = 3'd1;
	localparam logic [2:0] FN_READ   = 3'd2;
	localparam logic [2:0] FN_DELETE = 3'd3;
	localparam logic [2:0] FN_PACK   = 3'd4;

	localparam logic ST_DONE    = 1'b0;
	localparam logic ST_REFUSED = 1'b1;

	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 80;

	typedef struct packed {
		logic        status;
		logic [9:0]  slot;
		logic [63:0] word;
		logic [3:0]  cnt;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [11:0] start;
		logic [11:0] len;
	} slot_ent_t;

endpackage

`default_nettype wire

// File: src/sprs_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module sprs_out_reg (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             load,
	input  sprs_pkg::res_t                  res,
	output logic                            space,
	output logic                            m_tvalid,
	input  wire                             m_tready,
	output logic [sprs_pkg::OUT_TDATA_W-1:0] m_tdata, // slot_result, read_word, byte_count
	output logic                            m_tuser,  // status
	output logic                            m_tlast   // last_word
);
	import sprs_pkg::*;

	res_t res_q;
	logic vld_q;

	assign space = !vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (m_tready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {2'b00, res_q.cnt, res_q.word, res_q.slot};
	assign m_tuser  = res_q.status;
	assign m_tlast  = res_q.last;

endmodule

`default_nettype wire

// File: src/slotted_page_record_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Slotted page record store: one database page as a byte memory plus a slot table.
// Input channel s_*: s_tuser is the command (init, insert word, read word, delete,
// compact), s_tlast marks the final data word of an insert, s_tdata the rest.
// Output channel m_*: one result item per command, none for non-final insert words.
// Sequencing, all sequential, one item at a time:
//   insert word: accept, then one page byte per cycle; the first word of an insert
//     first scans the slots for a deleted one, zeroes the reserved bytes, and runs a
//     compaction when a reused slot does not fit.
//   read: a check, then an address step and a fetch step per returned byte.
//   compact: per moved record, a min search over the slots in use, then a byte copy.
// Both memories are single-port-read, single-port-write with registered reads.
// Reset clears all control state; no memory sweep is needed since every byte a read
// can reach was zeroed when its record was placed.
// A finished result sits in an output register; the block takes the next item while
// it waits and stalls only when a second result is ready before the first is taken.
module slotted_page_record_store #(
	parameter int PAGE_BYTES       = sprs_pkg::DEF_PAGE_BYTES,
	parameter int HEADER_BYTES     = sprs_pkg::DEF_HEADER_BYTES,
	parameter int SLOT_ENTRY_BYTES = sprs_pkg::DEF_SLOT_ENTRY_BYTES,
	parameter int MAX_SLOTS        = sprs_pkg::DEF_MAX_SLOTS
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// slot_index, word_index, size, data_word (bits 9:0, 18:10, 30:19, 94:31)
	input  wire  [sprs_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  wire  [2:0]                       s_tuser,  // func
	input  wire                              s_tlast,  // data_last
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// slot_result, read_word, byte_count (bits 9:0, 73:10, 77:74)
	output logic [sprs_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                             m_tuser,  // status
	output logic                             m_tlast   // last_word
);
	import sprs_pkg::*;

	localparam int PW = $clog2(PAGE_BYTES);
	localparam int SW = $clog2(MAX_SLOTS);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_FS_RD  = 4'd1;
	localparam logic [3:0] S_FS_CHK = 4'd2;
	localparam logic [3:0] S_FS_FIT = 4'd3;
	localparam logic [3:0] S_PLACE  = 4'd4;
	localparam logic [3:0] S_ZERO   = 4'd5;
	localparam logic [3:0] S_WR     = 4'd6;
	localparam logic [3:0] S_RD_CHK = 4'd7;
	localparam logic [3:0] S_RD_ADR = 4'd8;
	localparam logic [3:0] S_RD_GET = 4'd9;
	localparam logic [3:0] S_DEL    = 4'd10;
	localparam logic [3:0] S_PK_RD  = 4'd11;
	localparam logic [3:0] S_PK_CHK = 4'd12;
	localparam logic [3:0] S_CP_RD  = 4'd13;
	localparam logic [3:0] S_CP_WR  = 4'd14;
	localparam logic [3:0] S_EMIT   = 4'd15;

	// memories
	logic [7:0]  page_mem [PAGE_BYTES];
	slot_ent_t   slot_mem [MAX_SLOTS];
	logic [7:0]  pg_rd_q;
	slot_ent_t   sl_rd_q;
	logic        pg_we;
	logic [PW-1:0] pg_waddr, pg_raddr;
	logic [7:0]  pg_wdata;
	logic        sl_we;
	logic [SW-1:0] sl_waddr, sl_raddr;
	slot_ent_t   sl_wdata;

	// control state
	logic [3:0]  state_q;
	logic [10:0] slots_used_q;
	logic [12:0] fb_q, ff_q, cursor_q;
	logic        open_q, refused_q;
	logic [9:0]  open_slot_q;
	logic [12:0] open_start_q;
	logic [11:0] open_len_q;
	logic [10:0] idx_q;
	logic [10:0] place_slot_q;
	logic [12:0] z_q, zend_q;
	logic [2:0]  b_q;
	logic        pk_ins_q;
	logic [12:0] next_q;
	logic [11:0] last_old_q;
	logic        any_q, pick_v_q;
	logic [10:0] pick_idx_q;
	logic [11:0] pick_start_q, pick_len_q;
	logic [12:0] cp_src_q, cp_dst_q, cp_cnt_q;
	logic [12:0] rd_ptr_q;
	res_t        res_q;

	// latched command
	logic [9:0]  sidx_q;
	logic [8:0]  widx_q;
	logic [11:0] size_q;
	logic [63:0] data_q;
	logic        last_q;

	logic        in_acc, out_space, out_load;
	logic [12:0] space_left, pos, size_w;
	logic [13:0] at;
	logic [11:0] rd_first, rd_rem;
	logic        pk_take;

	assign s_tready  = (state_q == S_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign out_load  = (state_q == S_EMIT) && out_space;
	assign space_left = (ff_q > fb_q) ? ff_q - fb_q : 13'd0;
	assign size_w    = {1'b0, size_q};
	assign pos       = cursor_q + {10'd0, b_q};
	assign at        = {1'b0, open_start_q} + {1'b0, pos};
	assign rd_first  = {widx_q, 3'b000};
	assign rd_rem    = sl_rd_q.len - rd_first;
	assign pk_take   = (sl_rd_q.len != 12'd0) && !(any_q && sl_rd_q.start <= last_old_q)
		&& (!pick_v_q || sl_rd_q.start < pick_start_q);

	// memory port control
	always_comb begin
		pg_we    = 1'b0;
		pg_waddr = z_q[PW-1:0];
		pg_wdata = 8'd0;
		pg_raddr = cp_src_q[PW-1:0];
		sl_we    = 1'b0;
		sl_waddr = place_slot_q[SW-1:0];
		sl_wdata = '{start: fb_q[11:0], len: size_q};
		sl_raddr = idx_q[SW-1:0];
		case (state_q)
			S_IDLE: sl_raddr = s_tdata[SW-1:0];
			S_PLACE: sl_we = 1'b1;
			S_ZERO: pg_we = (z_q < zend_q);
			S_WR: begin
				pg_we    = !refused_q && (pos < {1'b0, open_len_q})
					&& (at < 14'(PAGE_BYTES));
				pg_waddr = at[PW-1:0];
				pg_wdata = data_q[{b_q, 3'b000} +: 8];
			end
			S_RD_ADR: pg_raddr = rd_ptr_q[PW-1:0];
			S_DEL: begin
				sl_we    = ({1'b0, sidx_q} < slots_used_q) && (sl_rd_q.len != 12'd0);
				sl_waddr = sidx_q[SW-1:0];
				sl_wdata = '{start: sl_rd_q.start, len: 12'd0};
			end
			S_PK_RD: begin
				sl_we    = (idx_q >= slots_used_q) && pick_v_q;
				sl_waddr = pick_idx_q[SW-1:0];
				sl_wdata = '{start: next_q[11:0], len: pick_len_q};
			end
			S_CP_WR: begin
				pg_we    = 1'b1;
				pg_waddr = cp_dst_q[PW-1:0];
				pg_wdata = pg_rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pg_we) begin
			page_mem[pg_waddr] <= pg_wdata;
		end
		pg_rd_q <= page_mem[pg_raddr];
	end

	always_ff @(posedge clk) begin
		if (sl_we) begin
			slot_mem[sl_waddr] <= sl_wdata;
		end
		sl_rd_q <= slot_mem[sl_raddr];
	end

	// command latch
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sidx_q <= s_tdata[9:0];
			widx_q <= s_tdata[18:10];
			size_q <= s_tdata[30:19];
			data_q <= s_tdata[94:31];
			last_q <= s_tlast;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slots_used_q <= 11'd0;
			fb_q         <= 13'(HEADER_BYTES);
			ff_q         <= 13'(PAGE_BYTES);
			cursor_q     <= 13'd0;
			open_q       <= 1'b0;
			refused_q    <= 1'b0;
			open_slot_q  <= 10'd0;
			open_start_q <= 13'd0;
			open_len_q   <= 12'd0;
			idx_q        <= 11'd0;
			place_slot_q <= 11'd0;
			z_q          <= 13'd0;
			zend_q       <= 13'd0;
			b_q          <= 3'd0;
			pk_ins_q     <= 1'b0;
			next_q       <= 13'd0;
			last_old_q   <= 12'd0;
			any_q        <= 1'b0;
			pick_v_q     <= 1'b0;
			pick_idx_q   <= 11'd0;
			pick_start_q <= 12'd0;
			pick_len_q   <= 12'd0;
			cp_src_q     <= 13'd0;
			cp_dst_q     <= 13'd0;
			cp_cnt_q     <= 13'd0;
			rd_ptr_q     <= 13'd0;
			res_q        <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						res_q <= '0;
						if (s_tuser != FN_INSERT) begin
							open_q   <= 1'b0;
							cursor_q <= 13'd0;
						end
						case (s_tuser)
							FN_INIT: begin
								slots_used_q <= 11'd0;
								fb_q         <= 13'(HEADER_BYTES);
								ff_q         <= 13'(PAGE_BYTES);
								state_q      <= S_EMIT;
							end
							FN_INSERT: begin
								b_q <= 3'd0;
								idx_q <= 11'd0;
								state_q <= open_q ? S_WR : S_FS_RD;
							end
							FN_READ:   state_q <= S_RD_CHK;
							FN_DELETE: state_q <= S_DEL;
							FN_PACK: begin
								pk_ins_q <= 1'b0;
								idx_q    <= 11'd0;
								pick_v_q <= 1'b0;
								any_q    <= 1'b0;
								next_q   <= 13'(HEADER_BYTES);
								state_q  <= S_PK_RD;
							end
							default: begin
								res_q.status <= ST_REFUSED;
								state_q      <= S_EMIT;
							end
						endcase
					end
				end
				// look for the first deleted slot, else append a new one or refuse
				S_FS_RD: begin
					if (idx_q >= slots_used_q) begin
						if (slots_used_q >= 11'(MAX_SLOTS)
							|| size_w + 13'(SLOT_ENTRY_BYTES) > space_left) begin
							open_q    <= 1'b1;
							refused_q <= 1'b1;
							cursor_q  <= 13'd0;
							state_q   <= S_WR;
						end else begin
							place_slot_q <= slots_used_q;
							ff_q         <= ff_q - 13'(SLOT_ENTRY_BYTES);
							slots_used_q <= slots_used_q + 11'd1;
							state_q      <= S_PLACE;
						end
					end else begin
						state_q <= S_FS_CHK;
					end
				end
				S_FS_CHK: begin
					if (sl_rd_q.len == 12'd0) begin
						place_slot_q <= idx_q;
						if (size_w > space_left) begin
							pk_ins_q <= 1'b1;
							idx_q    <= 11'd0;
							pick_v_q <= 1'b0;
							any_q    <= 1'b0;
							next_q   <= 13'(HEADER_BYTES);
							state_q  <= S_PK_RD;
						end else begin
							state_q <= S_PLACE;
						end
					end else begin
						idx_q   <= idx_q + 11'd1;
						state_q <= S_FS_RD;
					end
				end
				S_FS_FIT: begin
					if (size_w > space_left) begin
						open_q    <= 1'b1;
						refused_q <= 1'b1;
						cursor_q  <= 13'd0;
						state_q   <= S_WR;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					open_q       <= 1'b1;
					refused_q    <= 1'b0;
					open_slot_q  <= place_slot_q[9:0];
					open_start_q <= fb_q;
					open_len_q   <= size_q;
					cursor_q     <= 13'd0;
					z_q          <= fb_q;
					zend_q       <= fb_q + size_w;
					fb_q         <= fb_q + size_w;
					state_q      <= S_ZERO;
				end
				S_ZERO: begin
					if (z_q < zend_q) begin
						z_q <= z_q + 13'd1;
					end else begin
						b_q     <= 3'd0;
						state_q <= S_WR;
					end
				end
				// one byte of the data word per cycle
				S_WR: begin
					b_q <= b_q + 3'd1;
					if (b_q == 3'd7) begin
						if (last_q) begin
							res_q.status <= refused_q;
							res_q.slot   <= refused_q ? 10'd0 : open_slot_q;
							open_q       <= 1'b0;
							cursor_q     <= 13'd0;
							state_q      <= S_EMIT;
						end else begin
							if (cursor_q < 13'(PAGE_BYTES)) begin
								cursor_q <= cursor_q + 13'd8;
							end
							state_q <= S_IDLE;
						end
					end
				end
				S_RD_CHK: begin
					if ({1'b0, sidx_q} >= slots_used_q || sl_rd_q.len == 12'd0
						|| rd_first >= sl_rd_q.len) begin
						res_q.status <= ST_REFUSED;
						state_q      <= S_EMIT;
					end else begin
						rd_ptr_q   <= {1'b0, sl_rd_q.start} + {1'b0, rd_first};
						res_q.cnt  <= (rd_rem > 12'd8) ? 4'd8 : rd_rem[3:0];
						res_q.last <= (rd_rem <= 12'd8);
						b_q        <= 3'd0;
						state_q    <= S_RD_ADR;
					end
				end
				S_RD_ADR: state_q <= S_RD_GET;
				S_RD_GET: begin
					res_q.word[{b_q, 3'b000} +: 8] <= pg_rd_q;
					b_q      <= b_q + 3'd1;
					rd_ptr_q <= rd_ptr_q + 13'd1;
					state_q  <= ({1'b0, b_q} + 4'd1 == res_q.cnt) ? S_EMIT : S_RD_ADR;
				end
				S_DEL: begin
					if ({1'b0, sidx_q} >= slots_used_q || sl_rd_q.len == 12'd0) begin
						res_q.status <= ST_REFUSED;
					end
					state_q <= S_EMIT;
				end
				// compaction: find lowest start above the last record moved
				S_PK_RD: begin
					if (idx_q >= slots_used_q) begin
						if (!pick_v_q) begin
							fb_q    <= next_q;
							state_q <= pk_ins_q ? S_FS_FIT : S_EMIT;
						end else begin
							cp_src_q   <= {1'b0, pick_start_q};
							cp_dst_q   <= next_q;
							cp_cnt_q   <= {1'b0, pick_len_q};
							next_q     <= next_q + {1'b0, pick_len_q};
							last_old_q <= pick_start_q;
							any_q      <= 1'b1;
							state_q    <= S_CP_RD;
						end
					end else begin
						state_q <= S_PK_CHK;
					end
				end
				S_PK_CHK: begin
					if (pk_take) begin
						pick_v_q     <= 1'b1;
						pick_idx_q   <= idx_q;
						pick_start_q <= sl_rd_q.start;
						pick_len_q   <= sl_rd_q.len;
					end
					idx_q   <= idx_q + 11'd1;
					state_q <= S_PK_RD;
				end
				S_CP_RD: begin
					if (cp_cnt_q == 13'd0) begin
						idx_q    <= 11'd0;
						pick_v_q <= 1'b0;
						state_q  <= S_PK_RD;
					end else begin
						state_q <= S_CP_WR;
					end
				end
				S_CP_WR: begin
					cp_src_q <= cp_src_q + 13'd1;
					cp_dst_q <= cp_dst_q + 13'd1;
					cp_cnt_q <= cp_cnt_q - 13'd1;
					state_q  <= S_CP_RD;
				end
				S_EMIT: begin
					if (out_space) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	sprs_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (out_load),
		.res      (res_q),
		.space    (out_space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTHESIS
	a_free_order: assert property (@(posedge clk) disable iff (!arst_n)
		fb_q <= ff_q) else $error("free region inverted");
	a_slot_cap: assert property (@(posedge clk) disable iff (!arst_n)
		slots_used_q <= 11'(MAX_SLOTS)) else $error("slot count overflow");
	a_refused_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR && refused_q) |-> !pg_we) else $error("write on refused insert");
	a_copy_down: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CP_WR) |-> (cp_dst_q <= cp_src_q)) else $error("copy moves upward");
	a_emit_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid) else $error("result lost");
`endif

endmodule

`default_nettype wire
